// ----- hw/rtl/epmsc_pkg.sv -----
// shared types, constants and helpers of the encoder pid speed controller
`timescale 1ns / 1ps
`default_nettype none
package epmsc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      OP_SAMPLE  = 3'd0,
      OP_SPEED   = 3'd1,
      OP_RUN     = 3'd2,
      OP_STOP    = 3'd3,
      OP_BRAKE   = 3'd4,
      OP_RESTART = 3'd5,
      OP_CLEAR   = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_ENCODER_ENABLE     = 3'd0,
      CSR_PULSES_PER_REV     = 3'd1,
      CSR_GAIN_P             = 3'd2,
      CSR_GAIN_I             = 3'd3,
      CSR_GAIN_D             = 3'd4,
      CSR_DIRECTION_REVERSED = 3'd5
   } csr_index_type;

   localparam logic [6:0] DUTY_FULL = 7'd100;

   // x4 quadrature decode of {previous a, previous b, a, b}
   function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
      logic signed [1:0] d;
      begin
         case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
            default: d = 2'sd0;
         endcase
         return d;
      end
   endfunction

   function automatic logic [6:0] sat_duty(input logic [31:0] m);
      begin
         return (m > 32'(DUTY_FULL)) ? DUTY_FULL : m[6:0];
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/encoder_pid_motor_speed_controller.sv -----
// encoder pid motor speed controller: quadrature count, speed estimate, pid, bridge duty
// every opcode but the speed step goes from idle straight to the done state
// the speed step runs a shared bit-serial multiplier (one multiplier bit a cycle) and a
// shared restoring divider (one quotient bit a cycle, 24 or 64 bits)
// one item at a time; the next transfer is taken once the result is in the output register
// synchronous active-high reset clears all registers, config to zero, time records unset
`timescale 1ns / 1ps
`default_nettype none
module encoder_pid_motor_speed_controller
   import epmsc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_opcode,
   input  wire logic               req_encoder_a,
   input  wire logic               req_encoder_b,
   input  wire logic signed [23:0] req_target_speed,
   input  wire logic signed [15:0] req_duty_command,
   input  wire logic [31:0]        req_now_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [6:0]              rsp_duty_a,
   output logic [6:0]              rsp_duty_b,
   output logic signed [23:0]      rsp_speed_rps,
   output logic signed [31:0]      rsp_pulse_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   localparam int CW  = COUNT_WIDTH;
   localparam int AW  = (CW + 22 > 64) ? CW + 22 : 64;
   localparam int DRW = 48;
   localparam int DQW = 64;
   localparam int MW  = 32;
   localparam int SW  = 60;
   localparam logic [MW-1:0] SPEED_SCALE = 32'd4096000;
   localparam logic [MW-1:0] MILLI = 32'd1000;
   localparam logic [31:0] DT_DEFAULT = 32'd10;
   localparam logic signed [53:0] ISUM_MAX = 54'sd2147483647;
   localparam logic signed [53:0] ISUM_MIN = -54'sd2147483648;
   localparam logic signed [SW-1:0] OUT_HI = 60'sd1677721600;
   localparam logic signed [SW-1:0] OUT_LO = -60'sd1677721600;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SPEED, ST_DEN, ST_SNUM, ST_SPDSET, ST_PIDCHK, ST_IDIV, ST_ISUM,
      ST_DDIV, ST_DSET, ST_PADD, ST_IADD, ST_DADD, ST_OUT, ST_MUL, ST_DIV, ST_DONE
   } state_type;

   state_type state_ff, mul_ret_ff, div_ret_ff;

   logic                  enc_en_ff, rev_ff;
   logic [15:0]           ppr_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic [1:0]            quad_ff;
   logic signed [CW-1:0]  count_now_ff, count_last_ff;
   logic [31:0]           t_last_ff, t_pid_ff, now_ff, dt_ff;
   logic                  spd_valid_ff, pid_valid_ff;
   logic signed [23:0]    speed_ff, target_ff;
   logic signed [31:0]    integral_ff;
   logic signed [24:0]    eb_ff, err_ff;
   logic [6:0]            duty_a_ff, duty_b_ff;
   logic                  diff_neg_ff, over_ff, term_neg_ff;
   logic [35:0]           deriv_ff;
   logic signed [SW-1:0]  sum_ff;
   logic [AW-1:0]         acc_ff, mcand_ff;
   logic [MW-1:0]         mul_m_ff;
   logic [DRW-1:0]        div_r_ff, div_d_ff;
   logic [DQW-1:0]        div_q_ff;
   logic [6:0]            div_cnt_ff;
   logic                  rsp_valid_ff;
   logic [6:0]            rsp_a_ff, rsp_b_ff;
   logic signed [23:0]    rsp_speed_ff;
   logic signed [31:0]    rsp_count_ff;

   logic [1:0]            pins;
   logic signed [1:0]     qstep;
   logic [CW-1:0]         delta, dmag;
   logic                  dneg;
   logic [31:0]           elapsed;
   logic [AW-1:0]         n_hi;
   logic [DRW:0]          dv_t, dv_sub;
   logic                  dv_ge;
   logic signed [24:0]    err_val;
   logic [24:0]           err_abs;
   logic signed [25:0]    diff_val;
   logic [25:0]           diff_abs;
   logic signed [53:0]    iq_s, isum_wide;
   logic signed [31:0]    isum_sat;
   logic [31:0]           isum_abs;
   logic [15:0]           gp_abs, gi_abs, gd_abs;
   logic [SW-1:0]         term_mag;
   logic signed [SW-1:0]  term_val, sum_abs;
   logic [15:0]           cmd_abs;
   logic [23:0]           tgt_abs;
   logic                  drv_neg;
   logic [6:0]            drv_mag;
   logic [23:0]           q24;
   logic                  gains_zero;

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_a      = rsp_a_ff;
   assign rsp_duty_b      = rsp_b_ff;
   assign rsp_speed_rps   = rsp_speed_ff;
   assign rsp_pulse_count = rsp_count_ff;

   always_comb begin
      pins     = {req_encoder_a, req_encoder_b};
      qstep    = quad_delta({quad_ff, pins});
      delta    = count_now_ff - count_last_ff;
      dneg     = delta[CW-1];
      dmag     = dneg ? (~delta + 1'b1) : delta;
      elapsed  = now_ff - t_last_ff;
      n_hi     = acc_ff >> 24;
      dv_t     = {div_r_ff, div_q_ff[DQW-1]};
      dv_sub   = dv_t - {1'b0, div_d_ff};
      dv_ge    = (dv_t >= {1'b0, div_d_ff});
      q24      = div_q_ff[23:0];
      err_val  = 25'(target_ff) - 25'(speed_ff);
      err_abs  = err_ff[24] ? 25'(-err_ff) : 25'(err_ff);
      diff_val = 26'(err_ff) - 26'(eb_ff);
      diff_abs = diff_val[25] ? 26'(-diff_val) : 26'(diff_val);
      iq_s     = err_ff[24] ? -$signed({1'b0, div_q_ff[52:0]})
                            : $signed({1'b0, div_q_ff[52:0]});
      isum_wide = 54'(integral_ff) + iq_s;
      if (isum_wide > ISUM_MAX) begin
         isum_sat = 32'sh7FFFFFFF;
      end else if (isum_wide < ISUM_MIN) begin
         isum_sat = -32'sh80000000;
      end else begin
         isum_sat = 32'(isum_wide);
      end
      isum_abs = integral_ff[31] ? 32'(-integral_ff) : 32'(integral_ff);
      gp_abs   = gain_p_ff[15] ? 16'(-gain_p_ff) : gain_p_ff;
      gi_abs   = gain_i_ff[15] ? 16'(-gain_i_ff) : gain_i_ff;
      gd_abs   = gain_d_ff[15] ? 16'(-gain_d_ff) : gain_d_ff;
      gains_zero = (gain_p_ff == 16'd0) && (gain_i_ff == 16'd0) && (gain_d_ff == 16'd0);
      if (state_ff == ST_IADD) begin
         term_mag = SW'(acc_ff[54:0]);
      end else begin
         term_mag = SW'({acc_ff[54:0], 4'b0});
      end
      term_val = term_neg_ff ? -$signed(term_mag) : $signed(term_mag);
      sum_abs  = sum_ff[SW-1] ? -sum_ff : sum_ff;
      cmd_abs  = req_duty_command[15] ? 16'(-req_duty_command) : 16'(req_duty_command);
      tgt_abs  = target_ff[23] ? 24'(-target_ff) : 24'(target_ff);
      case (state_ff)
         ST_IDLE: begin
            drv_neg = req_duty_command[15];
            drv_mag = sat_duty(32'(cmd_abs));
         end
         ST_PIDCHK: begin
            drv_neg = target_ff[23];
            drv_mag = sat_duty(32'(tgt_abs[23:12]));
         end
         default: begin
            if (sum_ff >= OUT_HI) begin
               drv_neg = 1'b0;
               drv_mag = DUTY_FULL;
            end else if (sum_ff <= OUT_LO) begin
               drv_neg = 1'b1;
               drv_mag = DUTY_FULL;
            end else begin
               drv_neg = sum_ff[SW-1];
               drv_mag = sum_abs[30:24];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_ret_ff    <= ST_IDLE;
         div_ret_ff    <= ST_IDLE;
         enc_en_ff     <= 1'b0;
         rev_ff        <= 1'b0;
         ppr_ff        <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         quad_ff       <= '0;
         count_now_ff  <= '0;
         count_last_ff <= '0;
         t_last_ff     <= '0;
         t_pid_ff      <= '0;
         spd_valid_ff  <= 1'b0;
         pid_valid_ff  <= 1'b0;
         speed_ff      <= '0;
         integral_ff   <= '0;
         eb_ff         <= '0;
         duty_a_ff     <= '0;
         duty_b_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_a_ff      <= '0;
         rsp_b_ff      <= '0;
         rsp_speed_ff  <= '0;
         rsp_count_ff  <= '0;
         now_ff        <= '0;
         dt_ff         <= '0;
         target_ff     <= '0;
         err_ff        <= '0;
         diff_neg_ff   <= 1'b0;
         over_ff       <= 1'b0;
         term_neg_ff   <= 1'b0;
         deriv_ff      <= '0;
         sum_ff        <= '0;
         acc_ff        <= '0;
         mcand_ff      <= '0;
         mul_m_ff      <= '0;
         div_r_ff      <= '0;
         div_d_ff      <= '0;
         div_q_ff      <= '0;
         div_cnt_ff    <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_ENCODER_ENABLE:     enc_en_ff <= csr_data[0];
               CSR_PULSES_PER_REV:     ppr_ff    <= csr_data;
               CSR_GAIN_P:             gain_p_ff <= csr_data;
               CSR_GAIN_I:             gain_i_ff <= csr_data;
               CSR_GAIN_D:             gain_d_ff <= csr_data;
               CSR_DIRECTION_REVERSED: rev_ff    <= csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= (opcode_type'(req_opcode) == OP_SPEED) ? ST_SPEED : ST_DONE;
                  case (opcode_type'(req_opcode))
                     OP_SAMPLE: begin
                        if (enc_en_ff) begin
                           count_now_ff <= count_now_ff + CW'(qstep);
                           quad_ff      <= pins;
                        end
                     end
                     OP_SPEED: begin
                        target_ff <= req_target_speed;
                        now_ff    <= req_now_ms;
                     end
                     OP_RUN: begin
                        duty_a_ff <= (drv_neg == rev_ff) ? drv_mag : 7'd0;
                        duty_b_ff <= (drv_neg != rev_ff) ? drv_mag : 7'd0;
                     end
                     OP_STOP: begin
                        duty_a_ff <= 7'd0;
                        duty_b_ff <= 7'd0;
                     end
                     OP_BRAKE: begin
                        duty_a_ff <= DUTY_FULL;
                        duty_b_ff <= DUTY_FULL;
                     end
                     OP_RESTART: begin
                        count_now_ff  <= '0;
                        count_last_ff <= '0;
                        speed_ff      <= '0;
                        spd_valid_ff  <= 1'b0;
                        t_last_ff     <= '0;
                        quad_ff       <= pins;
                     end
                     OP_CLEAR: begin
                        count_now_ff  <= '0;
                        count_last_ff <= '0;
                        spd_valid_ff  <= 1'b0;
                        t_last_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SPEED: begin
               if (enc_en_ff && ppr_ff != 16'd0 && spd_valid_ff && elapsed != 32'd0) begin
                  acc_ff     <= '0;
                  mcand_ff   <= AW'(elapsed);
                  mul_m_ff   <= MW'(ppr_ff);
                  mul_ret_ff <= ST_DEN;
                  state_ff   <= ST_MUL;
               end else begin
                  state_ff <= ST_PIDCHK;
                  if (enc_en_ff) begin
                     if (ppr_ff == 16'd0) begin
                        speed_ff <= '0;
                     end else if (!spd_valid_ff) begin
                        spd_valid_ff  <= 1'b1;
                        t_last_ff     <= now_ff;
                        count_last_ff <= count_now_ff;
                        speed_ff      <= '0;
                     end
                  end
               end
            end
            ST_DEN: begin
               div_d_ff   <= acc_ff[DRW-1:0];
               acc_ff     <= '0;
               mcand_ff   <= AW'(dmag);
               mul_m_ff   <= SPEED_SCALE;
               mul_ret_ff <= ST_SNUM;
               state_ff   <= ST_MUL;
            end
            ST_SNUM: begin
               // quotient of 2^24 or more saturates, else 24 quotient bits remain
               if (n_hi >= AW'(div_d_ff)) begin
                  over_ff  <= 1'b1;
                  state_ff <= ST_SPDSET;
               end else begin
                  over_ff    <= 1'b0;
                  div_r_ff   <= DRW'(n_hi);
                  div_q_ff   <= {acc_ff[23:0], (DQW - 24)'(0)};
                  div_cnt_ff <= 7'd24;
                  div_ret_ff <= ST_SPDSET;
                  state_ff   <= ST_DIV;
               end
            end
            ST_SPDSET: begin
               if (dneg) begin
                  speed_ff <= (over_ff || q24 >= 24'h800000) ? -24'sh800000 : -$signed(q24);
               end else begin
                  speed_ff <= (over_ff || q24 >= 24'h7FFFFF) ? 24'sh7FFFFF : $signed(q24);
               end
               count_last_ff <= count_now_ff;
               t_last_ff     <= now_ff;
               state_ff      <= ST_PIDCHK;
            end
            ST_PIDCHK: begin
               if (!enc_en_ff || gains_zero) begin
                  duty_a_ff <= (drv_neg == rev_ff) ? drv_mag : 7'd0;
                  duty_b_ff <= (drv_neg != rev_ff) ? drv_mag : 7'd0;
                  state_ff  <= ST_DONE;
               end else begin
                  dt_ff      <= (pid_valid_ff && now_ff > t_pid_ff) ? now_ff - t_pid_ff
                                                                    : DT_DEFAULT;
                  err_ff     <= err_val;
                  acc_ff     <= '0;
                  mcand_ff   <= AW'(err_val[24] ? 25'(-err_val) : 25'(err_val));
                  mul_m_ff   <= (pid_valid_ff && now_ff > t_pid_ff) ? now_ff - t_pid_ff
                                                                    : DT_DEFAULT;
                  mul_ret_ff <= ST_IDIV;
                  state_ff   <= ST_MUL;
               end
            end
            ST_IDIV: begin
               div_r_ff   <= '0;
               div_q_ff   <= {acc_ff[DQW-5:0], 4'b0};
               div_d_ff   <= DRW'(MILLI);
               div_cnt_ff <= 7'(DQW);
               div_ret_ff <= ST_ISUM;
               state_ff   <= ST_DIV;
            end
            ST_ISUM: begin
               integral_ff <= isum_sat;
               diff_neg_ff <= diff_val[25];
               acc_ff      <= '0;
               mcand_ff    <= AW'(diff_abs);
               mul_m_ff    <= MILLI;
               mul_ret_ff  <= ST_DDIV;
               state_ff    <= ST_MUL;
            end
            ST_DDIV: begin
               div_r_ff   <= '0;
               div_q_ff   <= acc_ff[DQW-1:0];
               div_d_ff   <= DRW'(dt_ff);
               div_cnt_ff <= 7'(DQW);
               div_ret_ff <= ST_DSET;
               state_ff   <= ST_DIV;
            end
            ST_DSET: begin
               deriv_ff    <= div_q_ff[35:0];
               sum_ff      <= '0;
               term_neg_ff <= err_ff[24] ^ gain_p_ff[15];
               acc_ff      <= '0;
               mcand_ff    <= AW'(err_abs);
               mul_m_ff    <= MW'(gp_abs);
               mul_ret_ff  <= ST_PADD;
               state_ff    <= ST_MUL;
            end
            ST_PADD: begin
               sum_ff      <= sum_ff + term_val;
               term_neg_ff <= integral_ff[31] ^ gain_i_ff[15];
               acc_ff      <= '0;
               mcand_ff    <= AW'(isum_abs);
               mul_m_ff    <= MW'(gi_abs);
               mul_ret_ff  <= ST_IADD;
               state_ff    <= ST_MUL;
            end
            ST_IADD: begin
               sum_ff      <= sum_ff + term_val;
               term_neg_ff <= diff_neg_ff ^ gain_d_ff[15];
               acc_ff      <= '0;
               mcand_ff    <= AW'(deriv_ff);
               mul_m_ff    <= MW'(gd_abs);
               mul_ret_ff  <= ST_DADD;
               state_ff    <= ST_MUL;
            end
            ST_DADD: begin
               sum_ff   <= sum_ff + term_val;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               duty_a_ff    <= (drv_neg == rev_ff) ? drv_mag : 7'd0;
               duty_b_ff    <= (drv_neg != rev_ff) ? drv_mag : 7'd0;
               eb_ff        <= err_ff;
               t_pid_ff     <= now_ff;
               pid_valid_ff <= 1'b1;
               state_ff     <= ST_DONE;
            end
            ST_MUL: begin
               // shift-add, one multiplier bit a cycle
               if (mul_m_ff == '0) begin
                  state_ff <= mul_ret_ff;
               end else begin
                  if (mul_m_ff[0]) begin
                     acc_ff <= acc_ff + mcand_ff;
                  end
                  mcand_ff <= mcand_ff << 1;
                  mul_m_ff <= mul_m_ff >> 1;
               end
            end
            ST_DIV: begin
               // restoring divide, one quotient bit a cycle
               if (div_cnt_ff == 7'd0) begin
                  state_ff <= div_ret_ff;
               end else begin
                  div_r_ff   <= dv_ge ? dv_sub[DRW-1:0] : dv_t[DRW-1:0];
                  div_q_ff   <= {div_q_ff[DQW-2:0], dv_ge};
                  div_cnt_ff <= div_cnt_ff - 7'd1;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_a_ff     <= duty_a_ff;
                  rsp_b_ff     <= duty_b_ff;
                  rsp_speed_ff <= speed_ff;
                  rsp_count_ff <= 32'(count_now_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- tb/sv/tb_encoder_pid_motor_speed_controller.sv -----
// testbench of the encoder pid motor speed controller with a built-in predictor
`timescale 1ns / 1ps
module tb_encoder_pid_motor_speed_controller;
   import epmsc_pkg::*;

   typedef struct {
      logic [2:0]         op;
      logic               a;
      logic               b;
      logic signed [23:0] target;
      logic signed [15:0] duty;
      logic [31:0]        now;
   } motor_cmd_type;

   typedef struct {
      logic [6:0]         duty_a;
      logic [6:0]         duty_b;
      logic signed [23:0] speed;
      logic signed [31:0] count;
   } bridge_state_type;

   localparam int SETTLE_CYCLES = 330;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint SPEED_CAP = 64'h100_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_opcode = '0;
   logic req_encoder_a = 1'b0;
   logic req_encoder_b = 1'b0;
   logic signed [23:0] req_target_speed = '0;
   logic signed [15:0] req_duty_command = '0;
   logic [31:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [6:0] rsp_duty_a;
   logic [6:0] rsp_duty_b;
   logic signed [23:0] rsp_speed_rps;
   logic signed [31:0] rsp_pulse_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   encoder_pid_motor_speed_controller u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   motor_cmd_type cmd_queue[$];
   bridge_state_type bridge_expect[$];
   int n_queued = 0;
   int n_taken = 0;
   int errors = 0;
   bit quiet = 1'b0;
   bit req_taken = 1'b0;

   // predictor state
   bit m_enable, m_reversed;
   logic [15:0] m_ppr;
   logic signed [15:0] m_kp, m_ki, m_kd;
   logic [1:0] m_quad;
   logic [31:0] m_count, m_count_last, m_time_speed, m_time_pid;
   bit m_speed_valid, m_pid_valid;
   logic signed [23:0] m_speed;
   logic signed [31:0] m_integral;
   logic signed [24:0] m_err_prev;
   logic [6:0] m_out_a, m_out_b;
   int quad_step[16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

   function automatic void set_bridge(longint duty);
      logic [6:0] pa, pb;
      pa = 0;
      pb = 0;
      if (duty > 100) duty = 100;
      if (duty < -100) duty = -100;
      if (duty > 0) pa = 7'(duty);
      else if (duty < 0) pb = 7'(-duty);
      m_out_a = m_reversed ? pb : pa;
      m_out_b = m_reversed ? pa : pb;
   endfunction

   function automatic void estimate_speed(logic [31:0] now);
      logic [31:0] elapsed, delta, mag;
      logic [127:0] num, den, q;
      bit neg;
      if (m_ppr == 0) begin
         m_speed = 0;
         return;
      end
      if (!m_speed_valid) begin
         m_speed_valid = 1;
         m_time_speed = now;
         m_count_last = m_count;
         m_speed = 0;
         return;
      end
      elapsed = now - m_time_speed;
      if (elapsed == 0) return;
      delta = m_count - m_count_last;
      neg = delta[31];
      mag = neg ? -delta : delta;
      num = 128'(mag) * 128'd4096000;
      den = 128'(m_ppr) * 128'(elapsed);
      q = num / den;
      if (q > SPEED_CAP) q = SPEED_CAP;
      if (neg) m_speed = (q >= 128'h80_0000) ? -24'sd8388608 : 24'(-q);
      else m_speed = (q >= 128'h7F_FFFF) ? 24'sd8388607 : 24'(q);
      m_count_last = m_count;
      m_time_speed = now;
   endfunction

   function automatic void speed_control(longint target, logic [31:0] now);
      longint dt, err, isum, deriv, u;
      if (m_enable) estimate_speed(now);
      if (!m_enable || (m_kp == 0 && m_ki == 0 && m_kd == 0)) begin
         set_bridge(target / 4096);
         return;
      end
      dt = (m_pid_valid && now > m_time_pid) ? longint'(now - m_time_pid) : 10;
      err = target - longint'(m_speed);
      isum = longint'(m_integral) + (err * dt * 16) / 1000;
      if (isum > 64'sd2147483647) isum = 64'sd2147483647;
      if (isum < -64'sd2147483648) isum = -64'sd2147483648;
      m_integral = 32'(isum);
      deriv = ((err - longint'(m_err_prev)) * 1000) / dt;
      u = longint'(m_kp) * err * 16 + longint'(m_ki) * isum + longint'(m_kd) * deriv * 16;
      m_err_prev = 25'(err);
      m_time_pid = now;
      m_pid_valid = 1;
      if (u >= (64'sd100 <<< 24)) set_bridge(100);
      else if (u <= -(64'sd100 <<< 24)) set_bridge(-100);
      else set_bridge(u / 16777216);
   endfunction

   function automatic bridge_state_type apply_cmd(motor_cmd_type c);
      bridge_state_type r;
      logic [1:0] pins;
      pins = {c.a, c.b};
      case (c.op)
         OP_SAMPLE: if (m_enable) begin
            m_count = m_count + 32'(quad_step[{m_quad, pins}]);
            m_quad = pins;
         end
         OP_SPEED: speed_control(longint'(c.target), c.now);
         OP_RUN: set_bridge(longint'(c.duty));
         OP_STOP: begin
            m_out_a = 0;
            m_out_b = 0;
         end
         OP_BRAKE: begin
            m_out_a = DUTY_FULL;
            m_out_b = DUTY_FULL;
         end
         OP_RESTART: begin
            m_count = 0;
            m_count_last = 0;
            m_speed = 0;
            m_speed_valid = 0;
            m_time_speed = 0;
            m_quad = pins;
         end
         OP_CLEAR: begin
            m_count = 0;
            m_count_last = 0;
            m_speed_valid = 0;
            m_time_speed = 0;
         end
         default: ;
      endcase
      r.duty_a = m_out_a;
      r.duty_b = m_out_b;
      r.speed = m_speed;
      r.count = m_count;
      return r;
   endfunction

   // predictor update and result check at the rising edge
   always @(posedge clock) begin
      bridge_state_type e;
      motor_cmd_type c;
      req_taken <= req_valid && req_ready && !reset;
      if (reset) begin
         m_enable = 0; m_reversed = 0; m_ppr = 0; m_kp = 0; m_ki = 0; m_kd = 0;
         m_quad = 0; m_count = 0; m_count_last = 0; m_time_speed = 0; m_time_pid = 0;
         m_speed_valid = 0; m_pid_valid = 0; m_speed = 0; m_integral = 0;
         m_err_prev = 0; m_out_a = 0; m_out_b = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENCODER_ENABLE: m_enable = csr_data[0];
               CSR_PULSES_PER_REV: m_ppr = csr_data;
               CSR_GAIN_P: m_kp = csr_data;
               CSR_GAIN_I: m_ki = csr_data;
               CSR_GAIN_D: m_kd = csr_data;
               CSR_DIRECTION_REVERSED: m_reversed = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            c.op = req_opcode; c.a = req_encoder_a; c.b = req_encoder_b;
            c.target = req_target_speed; c.duty = req_duty_command; c.now = req_now_ms;
            bridge_expect.push_back(apply_cmd(c));
            n_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (bridge_expect.size() == 0) begin
               $error("unexpected result transfer");
               errors++;
            end else begin
               e = bridge_expect.pop_front();
               if (rsp_duty_a !== e.duty_a) begin
                  $error("duty_a expected %0d actual %0d", e.duty_a, rsp_duty_a);
                  errors++;
               end
               if (rsp_duty_b !== e.duty_b) begin
                  $error("duty_b expected %0d actual %0d", e.duty_b, rsp_duty_b);
                  errors++;
               end
               if (rsp_speed_rps !== e.speed) begin
                  $error("speed_rps expected %0d actual %0d", e.speed, rsp_speed_rps);
                  errors++;
               end
               if (rsp_pulse_count !== e.count) begin
                  $error("pulse_count expected %0d actual %0d", e.count, rsp_pulse_count);
                  errors++;
               end
            end
         end
      end
   end

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      motor_cmd_type c;
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            c = cmd_queue.pop_front();
            req_opcode <= c.op; req_encoder_a <= c.a; req_encoder_b <= c.b;
            req_target_speed <= c.target; req_duty_command <= c.duty; req_now_ms <= c.now;
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver with random stalls and one long hold-off
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && n_taken >= 300) begin
         hold_done <= 1'b1;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_all(bit en, logic [15:0] ppr, logic [15:0] kp, logic [15:0] ki,
                          logic [15:0] kd, bit rev);
      csr_write(CSR_ENCODER_ENABLE, {15'd0, en});
      csr_write(CSR_PULSES_PER_REV, ppr);
      csr_write(CSR_GAIN_P, kp);
      csr_write(CSR_GAIN_I, ki);
      csr_write(CSR_GAIN_D, kd);
      csr_write(CSR_DIRECTION_REVERSED, {15'd0, rev});
   endtask

   task automatic queue_cmd(opcode_type op, bit a, bit b, logic signed [23:0] target,
                            logic signed [15:0] duty, logic [31:0] now);
      motor_cmd_type c;
      c.op = op; c.a = a; c.b = b; c.target = target; c.duty = duty; c.now = now;
      cmd_queue.push_back(c);
      n_queued++;
   endtask

   task automatic wait_idle();
      wait (n_taken == n_queued && bridge_expect.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random stimulus: mostly clean quadrature walks between speed steps
   logic [1:0] walk_pins = 2'b00;
   logic [31:0] clock_ms = 32'd1000;
   task automatic random_burst(int n_items);
      motor_cmd_type c;
      int dir, k;
      logic [1:0] gray[4] = '{2'b00, 2'b01, 2'b11, 2'b10};
      dir = $urandom_range(0, 1) ? 1 : -1;
      for (int i = 0; i < n_items; i++) begin
         k = $urandom_range(0, 99);
         c.a = $urandom_range(0, 1); c.b = $urandom_range(0, 1);
         c.duty = $urandom;
         c.target = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                               : 24'($signed($urandom_range(0, 400000)) - 200000);
         c.now = clock_ms;
         if (k < 60) begin
            c.op = OP_SAMPLE;
            if ($urandom_range(0, 19) == 0) dir = -dir;
            for (int g = 0; g < 4; g++)
               if (gray[g] == walk_pins) begin
                  walk_pins = gray[(g + dir + 4) % 4];
                  break;
               end
            if ($urandom_range(0, 15) != 0) {c.a, c.b} = walk_pins;
            else walk_pins = {c.a, c.b};
         end else if (k < 82) begin
            c.op = OP_SPEED;
            case ($urandom_range(0, 9))
               0: clock_ms = clock_ms;
               1: clock_ms = clock_ms - $urandom_range(1, 50);
               2: clock_ms = $urandom;
               default: clock_ms = clock_ms + $urandom_range(1, 40);
            endcase
            c.now = clock_ms;
         end else if (k < 90) begin
            c.op = OP_RUN;
            if ($urandom_range(0, 1)) c.duty = 16'($signed($urandom_range(0, 240)) - 120);
         end else begin
            c.op = 3'($urandom_range(3, 7));
         end
         cmd_queue.push_back(c);
         n_queued++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      queue_cmd(OP_SPEED, 0, 0, 24'sd409600, 16'sd0, 32'd5);
      queue_cmd(OP_SPEED, 1, 1, -24'sd8388608, 16'sd0, 32'd6);
      queue_cmd(OP_RUN, 0, 0, 24'sd0, 16'sh7FFF, 32'd0);
      queue_cmd(OP_RUN, 1, 1, -24'sd1, -16'sh8000, 32'hFFFF_FFFF);
      queue_cmd(OP_RUN, 0, 0, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_BRAKE, 0, 0, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_STOP, 0, 0, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SAMPLE, 0, 1, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(opcode_type'(3'd7), 1, 1, 24'sh7FFFFF, 16'sd5, 32'd0);
      wait_idle();
      set_all(1, 16'd4, 16'sh0100, 16'sh0040, 16'sh0010, 1);
      queue_cmd(OP_RESTART, 0, 0, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SPEED, 0, 0, 24'sd40960, 16'sd0, 32'd100);
      queue_cmd(OP_SAMPLE, 0, 1, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SAMPLE, 1, 1, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SAMPLE, 1, 0, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SPEED, 0, 0, 24'sd40960, 16'sd0, 32'd100);
      queue_cmd(OP_SPEED, 0, 0, 24'sh7FFFFF, 16'sd0, 32'd110);
      queue_cmd(OP_SAMPLE, 0, 0, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SAMPLE, 0, 1, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SPEED, 0, 0, -24'sd8388608, 16'sd0, 32'd111);
      queue_cmd(OP_CLEAR, 0, 0, 24'sd0, 16'sd0, 32'd0);
      queue_cmd(OP_SPEED, 0, 0, 24'sd0, 16'sd0, 32'd90);
      queue_cmd(OP_RUN, 0, 0, 24'sd0, 16'sd50, 32'd0);
      queue_cmd(OP_RESTART, 1, 1, 24'sd0, 16'sd0, 32'd0);
      wait_idle();

      // random phases over several settings
      set_all(1, 16'd1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
      random_burst(220);
      wait_idle();
      set_all(1, 16'd65535, 16'sh8000, 16'sh7FFF, 16'sh8000, 1);
      random_burst(220);
      wait_idle();
      set_all(1, 16'd0, 16'sh0200, 16'sh0000, 16'sh0000, 0);
      random_burst(250);
      wait_idle();
      set_all(1, 16'd400, 16'sd0, 16'sd0, 16'sd0, 1);
      random_burst(250);
      wait_idle();
      set_all(0, 16'd100, 16'sh0100, 16'sh0100, 16'sh0100, 0);
      random_burst(250);
      wait_idle();
      for (int p = 0; p < 4; p++) begin
         set_all(1, 16'($urandom_range(1, 2000)), 16'($signed($urandom_range(0, 1024)) - 512),
                 16'($signed($urandom_range(0, 256)) - 128),
                 16'($signed($urandom_range(0, 64)) - 32), 1'($urandom_range(0, 1)));
         if (p == 3) quiet = 1'b1;
         random_burst(220);
         wait_idle();
      end

      if (errors == 0 && bridge_expect.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
